[design/five_to_six_pixel_upscaler_unit_defines.svh]
// Assertion macros for the five-to-six upscaler checker.
`ifndef FIVE_TO_SIX_PIXEL_UPSCALER_UNIT_DEFINES_SVH
`define FIVE_TO_SIX_PIXEL_UPSCALER_UNIT_DEFINES_SVH

// a implies b on the next edge, ignored while in reset
`define FSU_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("upscaler assertion failed");

// a implies b on the next edge, also checked through reset
`define FSU_ASSERT_NEXT_ALL(lbl, a, b) \
    lbl: assert property (@(posedge aclk) (a) |=> (b)) \
        else $error("upscaler assertion failed");

`endif

[design/fsu_pkg.sv]
// Shared constants and blend functions for the five-to-six upscaler.
package fsu_pkg;

    localparam int DestWidth  = 320;
    localparam int DestHeight = 240;
    localparam int SrcWidth   = 256;
    localparam int SrcHeight  = 192;

    localparam int PixW   = 8;
    localparam int IdxW   = 5;
    localparam int ColorW = 16;
    localparam int WordW  = 26;
    localparam int XW     = 9;
    localparam int YW     = 8;
    localparam int LineAW = 10;

    typedef logic [WordW-1:0]        word_t;
    typedef logic [4:0][WordW-1:0]   quint_t;

    // byte swap, then space the 565 channels apart
    function automatic word_t to_spaced(input logic [ColorW-1:0] v);
        logic [ColorW-1:0] p;
        p = {v[7:0], v[15:8]};
        return {p[15:11], 5'b0, p[10:5], 5'b0, p[4:0]};
    endfunction

    function automatic logic [ColorW-1:0] to_rgb565(input word_t w);
        return {w[25:21], w[15:10], w[4:0]};
    endfunction

    // one output of the 5-to-6 stretch; fraction bits fall into the gaps
    function automatic word_t wsel(input quint_t s, input logic [2:0] k);
        logic [WordW+1:0] q1;
        logic [WordW+1:0] q4;
        logic [WordW:0]   h2;
        logic [WordW:0]   h3;
        word_t            r;
        q1 = {2'b0, s[0]} + {2'b0, s[1]} + {2'b0, s[1]} + {2'b0, s[1]};
        q4 = {2'b0, s[3]} + {2'b0, s[3]} + {2'b0, s[3]} + {2'b0, s[4]};
        h2 = {1'b0, s[1]} + {1'b0, s[2]};
        h3 = {1'b0, s[2]} + {1'b0, s[3]};
        unique case (k)
            3'd0:    r = s[0];
            3'd1:    r = q1[WordW+1:2];
            3'd2:    r = h2[WordW:1];
            3'd3:    r = h3[WordW:1];
            3'd4:    r = q4[WordW+1:2];
            default: r = s[4];
        endcase
        return r;
    endfunction

endpackage

[design/fsu_pal_ram.sv]
// Palette memory: 32 spaced colors, one write and one registered read port.
module fsu_pal_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [fsu_pkg::IdxW-1:0]        wr_addr,
    input  logic [fsu_pkg::ColorW-1:0]      wr_value,
    input  logic [fsu_pkg::IdxW-1:0]        rd_addr,
    output fsu_pkg::word_t                  rd_data
);
    import fsu_pkg::*;

    word_t mem [2**IdxW];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= to_spaced(wr_value);
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[design/fsu_line_ram.sv]
// Line store: four source rows of palette indices.
module fsu_line_ram (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [fsu_pkg::LineAW-1:0]   wr_addr,
    input  logic [fsu_pkg::IdxW-1:0]     wr_data,
    input  logic [fsu_pkg::LineAW-1:0]   rd_addr,
    output logic [fsu_pkg::IdxW-1:0]     rd_data
);
    import fsu_pkg::*;

    logic [IdxW-1:0] mem [2**LineAW];
    logic [IdxW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

[design/five_to_six_pixel_upscaler_unit.sv]
// Top level of the 256x192 to 307x230 five-to-six pixel upscaler.
// Input stream: s_tuser = 0 writes a palette entry (index, 16-bit byte-swapped
// RGB565 value); s_tuser = 1 delivers the next source pixel in raster order.
// Output stream: one request per destination pixel with its column, row and
// RGB565 color; m_tlast marks the final request caused by one input.
// A palette write or a pixel that gives no output leaves s_tready high.
// A pixel that closes a block gathers up to 5x5 source words through the line
// store and the palette memory, one palette read per cycle (up to 25 reads,
// then the two memory stages drain), then emits.
// Edge rows emit 6 requests (or 1 at the last column), one per cycle unless the output stalls.
// A band-closing pixel emits 36 requests in six columns (or 6 in one at the last column);
// each column is first loaded in the ST_COLLOAD state.
// Rate is set by the single palette read port and the one output register.
// The output register holds a request until m_tready; while it is stalled
// emission pauses, and s_tready stays low until the last request is loaded.
// Reset clears the raster position, the pixel history and the output valid;
// palette and line store contents are undefined until written.
module five_to_six_pixel_upscaler_unit #(
    parameter int DEST_HEIGHT = fsu_pkg::DestHeight
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // palette_index[4:0], palette_value[20:5], pixel[28:21]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // dest_x[8:0], dest_y[16:9], color[32:17]
    output logic        m_tlast
);
    import fsu_pkg::*;

    localparam int VPAD = (DEST_HEIGHT - 230) / 2;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_GATHER  = 2'd1;
    localparam logic [1:0] ST_COLLOAD = 2'd2;
    localparam logic [1:0] ST_EMIT    = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [PixW-1:0] row_reg, col_reg;
    logic [2:0]      colmod_reg;
    logic [5:0]      colgrp_reg;
    logic [2:0]      bk_reg;
    logic [5:0]      band_reg;
    logic [19:0]     hold_reg;

    // latched per item
    logic [IdxW-1:0] idx_reg;
    logic [PixW-1:0] pcol_reg;
    logic [19:0]     held_reg;
    logic            edge_reg, lastcol_reg;
    logic [XW-1:0]   xbase_reg;
    logic [YW-1:0]   ybase_reg;

    // gather sequencer
    logic            iss_reg;
    logic [2:0]      gr_reg, gc_reg, c0_reg;
    logic            p1v_reg, p2v_reg;
    logic [2:0]      p1r_reg, p1c_reg, p2r_reg, p2c_reg;
    logic [4:0][4:0][WordW-1:0] grid_reg;
    quint_t          colv_reg;

    logic [2:0]      ei_reg, ej_reg;

    logic              m_tvalid_reg;
    logic [XW-1:0]     ox_reg;
    logic [YW-1:0]     oy_reg;
    logic [ColorW-1:0] oc_reg;
    logic              olast_reg;

    logic            accept, pix_acc, pal_we;
    logic [IdxW-1:0] in_idx;
    logic            interior, gives, produce, line_we;
    logic [LineAW-1:0] line_waddr, line_raddr;
    logic [IdxW-1:0] line_rdata, pal_raddr, held_sel;
    word_t           pal_rdata;
    logic            gather_done, out_free;
    logic [PixW-1:0] gcol;
    word_t           emit_word;
    logic            emit_last;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign pal_we   = accept && !s_tuser;
    assign pix_acc  = accept && s_tuser;
    assign in_idx   = s_tdata[25:21];

    assign interior = (row_reg != '0) && (row_reg != PixW'(SrcHeight - 1));
    assign gives    = (col_reg == PixW'(SrcWidth - 1)) || (colmod_reg == 3'd4);
    assign produce  = pix_acc && gives && (!interior || bk_reg == 3'd4);
    assign line_we  = pix_acc && interior && (bk_reg != 3'd4);
    assign line_waddr = {bk_reg[1:0], col_reg};

    assign gcol       = pcol_reg - PixW'(4) + PixW'(gc_reg);
    assign line_raddr = {gr_reg[1:0], gcol};

    always_comb begin
        unique case (p1c_reg)
            3'd0:    held_sel = held_reg[19:15];
            3'd1:    held_sel = held_reg[14:10];
            3'd2:    held_sel = held_reg[9:5];
            3'd3:    held_sel = held_reg[4:0];
            default: held_sel = idx_reg;
        endcase
        pal_raddr = (p1r_reg == 3'd4) ? held_sel : line_rdata;
    end

    fsu_line_ram u_line (
        .aclk   (aclk),
        .wr_en  (line_we),
        .wr_addr(line_waddr),
        .wr_data(in_idx),
        .rd_addr(line_raddr),
        .rd_data(line_rdata)
    );

    fsu_pal_ram u_pal (
        .aclk    (aclk),
        .wr_en   (pal_we),
        .wr_addr (s_tdata[4:0]),
        .wr_value(s_tdata[20:5]),
        .rd_addr (pal_raddr),
        .rd_data (pal_rdata)
    );

    assign gather_done = !iss_reg && !p1v_reg && !p2v_reg;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign emit_word   = edge_reg ? wsel(grid_reg[4], ei_reg) : wsel(colv_reg, ej_reg);
    assign emit_last   = (ei_reg == 3'd5) && (edge_reg || ej_reg == 3'd5);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (produce) state_next = ST_GATHER;
            ST_GATHER:  if (gather_done) state_next = edge_reg ? ST_EMIT : ST_COLLOAD;
            ST_COLLOAD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end else if (!edge_reg && ej_reg == 3'd5) begin
                        state_next = ST_COLLOAD;
                    end
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            colmod_reg   <= '0;
            colgrp_reg   <= '0;
            bk_reg       <= '0;
            band_reg     <= '0;
            hold_reg     <= '0;
            iss_reg      <= 1'b0;
            p1v_reg      <= 1'b0;
            p2v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pix_acc) begin
                hold_reg <= {hold_reg[14:0], in_idx};
                col_reg  <= col_reg + PixW'(1);
                if (col_reg == PixW'(SrcWidth - 1)) begin
                    colmod_reg <= '0;
                    colgrp_reg <= '0;
                    row_reg <= (row_reg == PixW'(SrcHeight - 1)) ? '0 : row_reg + PixW'(1);
                    if (row_reg == '0) begin
                        bk_reg   <= '0;
                        band_reg <= '0;
                    end else if (bk_reg == 3'd4) begin
                        bk_reg   <= '0;
                        band_reg <= band_reg + 6'd1;
                    end else begin
                        bk_reg <= bk_reg + 3'd1;
                    end
                end else if (colmod_reg == 3'd4) begin
                    colmod_reg <= '0;
                    colgrp_reg <= colgrp_reg + 6'd1;
                end else begin
                    colmod_reg <= colmod_reg + 3'd1;
                end
            end

            if (produce) begin
                iss_reg <= 1'b1;
            end else if (iss_reg && gr_reg == 3'd4 && gc_reg == 3'd4) begin
                iss_reg <= 1'b0;
            end
            p1v_reg <= iss_reg;
            p2v_reg <= p1v_reg;

            if (state_reg == ST_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge aclk) begin
        if (pix_acc) begin
            idx_reg     <= in_idx;
            pcol_reg    <= col_reg;
            held_reg    <= hold_reg;
            edge_reg    <= !interior;
            lastcol_reg <= (col_reg == PixW'(SrcWidth - 1));
            xbase_reg   <= {1'b0, colgrp_reg, 2'b0} + {2'b0, colgrp_reg, 1'b0};
            if (row_reg == '0) begin
                ybase_reg <= YW'(VPAD);
            end else if (!interior) begin
                ybase_reg <= YW'(VPAD + 229);
            end else begin
                ybase_reg <= YW'(VPAD + 1) + {band_reg, 2'b0} + {1'b0, band_reg, 1'b0};
            end
        end
        if (produce) begin
            gr_reg <= interior ? 3'd0 : 3'd4;
            gc_reg <= (col_reg == PixW'(SrcWidth - 1)) ? 3'd4 : 3'd0;
            c0_reg <= (col_reg == PixW'(SrcWidth - 1)) ? 3'd4 : 3'd0;
            ei_reg <= (col_reg == PixW'(SrcWidth - 1)) ? 3'd5 : 3'd0;
            ej_reg <= '0;
        end else if (iss_reg) begin
            if (gc_reg == 3'd4) begin
                gc_reg <= c0_reg;
                gr_reg <= gr_reg + 3'd1;
            end else begin
                gc_reg <= gc_reg + 3'd1;
            end
        end
        p1r_reg <= gr_reg;
        p1c_reg <= gc_reg;
        p2r_reg <= p1r_reg;
        p2c_reg <= p1c_reg;
        if (p2v_reg) begin
            grid_reg[p2r_reg][p2c_reg] <= pal_rdata;
        end

        if (state_reg == ST_COLLOAD) begin
            for (int r = 0; r < 5; r++) begin
                colv_reg[r] <= wsel(grid_reg[r], ei_reg);
            end
        end

        if (state_reg == ST_EMIT && out_free) begin
            // the last column stays at its block's first destination column
            ox_reg    <= lastcol_reg ? xbase_reg : xbase_reg + XW'(ei_reg);
            oy_reg    <= edge_reg ? ybase_reg : ybase_reg + YW'(ej_reg);
            oc_reg    <= to_rgb565(emit_word);
            olast_reg <= emit_last;
            if (edge_reg) begin
                ei_reg <= ei_reg + 3'd1;
            end else if (ej_reg == 3'd5) begin
                ej_reg <= '0;
                ei_reg <= ei_reg + 3'd1;
            end else begin
                ej_reg <= ej_reg + 3'd1;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, oc_reg, oy_reg, ox_reg};
    assign m_tlast  = olast_reg;
endmodule

[design/fsu_checker.sv]
// Port-level checks for the five-to-six upscaler, bound to the top level.
`include "five_to_six_pixel_upscaler_unit_defines.svh"

module fsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);
    `FSU_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `FSU_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    `FSU_ASSERT_NEXT_ALL(a_reset_quiet, !aresetn, !m_tvalid && s_tready)
    `FSU_ASSERT_NEXT(a_palette_one_cycle, s_tvalid && s_tready && !s_tuser, s_tready)
    `FSU_ASSERT_NEXT(a_busy_until_last, m_tvalid && !m_tready && !m_tlast, !s_tready)
endmodule

bind five_to_six_pixel_upscaler_unit fsu_checker u_fsu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
